// ===== design/tctc_pkg.sv =====
package tctc_pkg;

  // Widths of the two divider passes
  localparam int D1_DW  = 36;  // t * fuse, t * 625, t * slope
  localparam int D2_DW  = 44;  // q * k, t * trim_diff, t * 16
  localparam int DIV_VW = 13;  // signed divisor width
  localparam int PROD2_W = D1_DW + 14;
  localparam int SUM_W  = D2_DW + 1;

  localparam int unsigned SLOPE_BASE = 57;
  localparam int unsigned TEMP_OFFSET = 2500;
  localparam int unsigned KNEE_DEG = 25;
  localparam int unsigned FIXED_GAIN_NUM = 625;
  localparam int unsigned HUNDRED = 100;
  localparam int unsigned LOW_DIV = 65;
  localparam int unsigned CODES_PER_DEG = 16;
  // floor(n / 100) = (n * RECIP_100) >> RECIP_SHIFT for n below 2**15
  localparam int unsigned RECIP_100 = 41944;
  localparam int unsigned RECIP_SHIFT = 22;

  localparam logic signed [SUM_W-1:0] I32_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] I32_MIN = -SUM_W'(64'sd2147483648);
  localparam logic signed [SUM_W-1:0] OFFSET_LIMIT = I32_MAX - SUM_W'(TEMP_OFFSET);

  typedef enum logic [1:0] {
    CFG_LOW_SLOPE_ADJUST = 2'd0,
    CFG_CALIBRATION_MODE = 2'd1,
    CFG_TEST_TEMP_HIGH   = 2'd2,
    CFG_TEST_TEMP_LOW    = 2'd3
  } cfg_idx_t;

  // 6500 / (57 + adj), low-temperature rescale factor
  typedef logic [6:0] k_tab_t [0:15];
  localparam k_tab_t LOW_K_TAB = '{
    7'd114, 7'd112, 7'd110, 7'd108, 7'd106, 7'd104, 7'd103, 7'd101,
    7'd100, 7'd98,  7'd97,  7'd95,  7'd94,  7'd92,  7'd91,  7'd90
  };

  // Per-item context carried alongside the divider passes
  typedef struct packed {
    logic                      mode;
    logic                      neg;
    logic                      err;
    logic [11:0]               trim_low;
    logic signed [12:0]        trim_diff;
  } side_t;

endpackage

// ===== design/tctc_div.sv =====
module tctc_div
  import tctc_pkg::*;
#(
  parameter int DW = 36,
  parameter int VW = 13,
  parameter int SW = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [DW-1:0] in_dividend,
  input  logic signed [VW-1:0] in_divisor,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [DW-1:0] out_quotient,
  output logic [SW-1:0]        out_side
);

  // stage 0 loads magnitudes, stages 1..DW retire one quotient bit, DW+1 signs
  logic          v_r    [0:DW+1];
  logic          adv    [0:DW+1];
  logic [SW-1:0] side_r [0:DW+1];
  logic [DW-1:0] q_r    [0:DW];
  logic [VW-1:0] rem_r  [0:DW];
  logic [VW-1:0] d_r    [0:DW];
  logic          neg_r  [0:DW];
  logic signed [DW-1:0] res_r;
  logic [DW-1:0] dvd_mag;
  logic [VW-1:0] dvs_mag;

  assign dvd_mag = in_dividend[DW-1] ? (~in_dividend + 1'b1) : in_dividend;
  assign dvs_mag = in_divisor[VW-1] ? (~in_divisor + 1'b1) : in_divisor;

  assign adv[DW+1] = !v_r[DW+1] || out_ready;
  assign in_ready  = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv[0]) begin
      v_r[0] <= in_valid;
    end
    if (adv[0] && in_valid) begin
      q_r[0]    <= dvd_mag;
      d_r[0]    <= dvs_mag;
      rem_r[0]  <= '0;
      neg_r[0]  <= in_dividend[DW-1] ^ in_divisor[VW-1];
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 1; k <= DW; k++) begin : g_step
    logic [VW:0] sh;
    logic        fit;
    assign adv[k-1] = !v_r[k-1] || adv[k];
    assign sh  = {rem_r[k-1], q_r[k-1][DW-1]};
    assign fit = sh >= {1'b0, d_r[k-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv[k]) begin
        v_r[k] <= v_r[k-1];
      end
      if (adv[k] && v_r[k-1]) begin
        rem_r[k]  <= fit ? VW'(sh - {1'b0, d_r[k-1]}) : sh[VW-1:0];
        q_r[k]    <= {q_r[k-1][DW-2:0], fit};
        d_r[k]    <= d_r[k-1];
        neg_r[k]  <= neg_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign adv[DW] = !v_r[DW] || adv[DW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[DW+1] <= 1'b0;
    end else if (adv[DW+1]) begin
      v_r[DW+1] <= v_r[DW];
    end
    if (adv[DW+1] && v_r[DW]) begin
      res_r        <= neg_r[DW] ? $signed(~q_r[DW] + 1'b1) : $signed(q_r[DW]);
      side_r[DW+1] <= side_r[DW];
    end
  end

  assign out_valid    = v_r[DW+1];
  assign out_quotient = res_r;
  assign out_side     = side_r[DW+1];

endmodule

// ===== design/thermal_code_temp_converter_top.sv =====
// Thermal code / temperature converter, two-point calibrated.
//
// Input stream: in_tdata carries trim_low, trim_high and value; in_tuser is
// the direction (0 code to temperature, 1 temperature to code). Result
// stream: out_tdata is the 32-bit signed result, out_tuser the divide error.
// Configuration: cfg_index selects slope adjust, calibration mode, hot and
// cold test temperature; cfg_data is written when cfg_valid is high
// (cfg_ready is always high). Write it only while no transaction is in flight.
//
// Throughput: one transaction per cycle unless the receiver stalls. Path:
// stages 1 and 2, bit-per-stage divider 1, stage 3, divider 2, output stage.
// Every stage carries its own valid bit and moves on whenever the stage
// after it is empty or moving, so a stalled receiver only backs up the
// pipeline as far as it is full; bubbles are squeezed out and input is still
// taken while results wait. Reset clears all valid bits and loads the
// register defaults; no transaction is lost or repeated across a stall.
module thermal_code_temp_converter_top
  import tctc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // trim_low[11:0], trim_high[23:12], value[42:24], pad
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // result[31:0]
  output logic        out_tuser,  // divide_error
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  localparam int SIDE_W = $bits(side_t);

  // configuration registers
  logic [3:0]  slope_adj_r;
  logic [1:0]  cal_mode_r;
  logic [14:0] temp_high_r;
  logic [14:0] temp_low_r;
  logic signed [9:0] fuse_q_r;  // (high - low) / 100, truncated

  logic signed [15:0] fuse;
  logic        trimmed;
  logic [6:0]  slope;
  logic [6:0]  low_k;

  assign cfg_ready = 1'b1;
  assign fuse    = $signed({1'b0, temp_high_r}) - $signed({1'b0, temp_low_r});
  assign trimmed = cal_mode_r[1];
  assign slope   = 7'(SLOPE_BASE) + {3'b000, slope_adj_r};
  assign low_k   = LOW_K_TAB[slope_adj_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slope_adj_r <= 4'd6;
      cal_mode_r  <= 2'd2;
      temp_high_r <= 15'd10500;
      temp_low_r  <= 15'd2500;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LOW_SLOPE_ADJUST: slope_adj_r <= cfg_data[3:0];
        CFG_CALIBRATION_MODE: cal_mode_r  <= cfg_data[1:0];
        CFG_TEST_TEMP_HIGH:   temp_high_r <= cfg_data;
        CFG_TEST_TEMP_LOW:    temp_low_r  <= cfg_data;
        default:              ;
      endcase
    end
  end

  // Fuse quotient by reciprocal; only read from stage 2 on, after it settles
  logic [14:0] fuse_mag;
  logic [30:0] fuse_prod;
  logic [8:0]  fuse_div;
  assign fuse_mag  = fuse[15] ? 15'(-fuse) : fuse[14:0];
  assign fuse_prod = 31'(fuse_mag) * 31'(RECIP_100);
  assign fuse_div  = fuse_prod[RECIP_SHIFT +: 9];

  always_ff @(posedge clk) begin
    fuse_q_r <= fuse[15] ? -$signed({1'b0, fuse_div}) : $signed({1'b0, fuse_div});
  end

  // Stage 1: offset the value, take the trim difference
  logic        v1_r, adv1, adv2;
  logic        mode1_r, neg1_r;
  logic [11:0] trim_low1_r;
  logic signed [12:0] trim_diff1_r;
  logic signed [19:0] t1_r;
  logic signed [19:0] t_nxt;
  logic [11:0] in_trim_low, in_trim_high;
  logic signed [18:0] in_value;

  assign in_trim_low  = in_tdata[11:0];
  assign in_trim_high = in_tdata[23:12];
  assign in_value     = $signed(in_tdata[42:24]);
  assign t_nxt = in_tuser ? (20'(in_value) - 20'(KNEE_DEG))
                          : (20'(in_value) - $signed({8'd0, in_trim_low}));

  assign adv1      = !v1_r || adv2;
  assign in_tready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_tvalid;
    end
    if (adv1 && in_tvalid) begin
      mode1_r      <= in_tuser;
      trim_low1_r  <= in_trim_low;
      trim_diff1_r <= $signed({1'b0, in_trim_high}) - $signed({1'b0, in_trim_low});
      t1_r         <= t_nxt;
      neg1_r       <= t_nxt[19];
    end
  end

  // Stage 2: first product and divisor
  logic        v2_r;
  logic        d1_in_ready;
  logic signed [D1_DW-1:0]  dvd1_r;
  logic signed [DIV_VW-1:0] dvs1_r;
  side_t       side2_r;
  logic signed [15:0] mul1_b;
  logic signed [DIV_VW-1:0] dvs1_nxt;
  logic        err_nxt;

  always_comb begin
    if (!mode1_r) begin
      mul1_b   = trimmed ? fuse : 16'(FIXED_GAIN_NUM);
      dvs1_nxt = trimmed ? trim_diff1_r : DIV_VW'(HUNDRED);
      err_nxt  = trimmed && (trim_diff1_r == '0);
    end else begin
      mul1_b   = neg1_r ? $signed({9'd0, slope}) : 16'sd1;
      dvs1_nxt = neg1_r ? DIV_VW'(LOW_DIV) : DIV_VW'(1);
      err_nxt  = trimmed && (fuse_q_r == '0);
    end
  end

  assign adv2 = !v2_r || d1_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r;
    end
    if (adv2 && v1_r) begin
      dvd1_r            <= D1_DW'(t1_r * mul1_b);
      dvs1_r            <= dvs1_nxt;
      side2_r.mode      <= mode1_r;
      side2_r.neg       <= neg1_r;
      side2_r.err       <= err_nxt;
      side2_r.trim_low  <= trim_low1_r;
      side2_r.trim_diff <= trim_diff1_r;
    end
  end

  logic        d1_out_valid, adv3;
  logic signed [D1_DW-1:0] q1;
  logic [SIDE_W-1:0] side_d1;

  tctc_div #(.DW(D1_DW), .VW(DIV_VW), .SW(SIDE_W)) u_div1 (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (v2_r),
    .in_ready     (d1_in_ready),
    .in_dividend  (dvd1_r),
    .in_divisor   (dvs1_r),
    .in_side      (side2_r),
    .out_valid    (d1_out_valid),
    .out_ready    (adv3),
    .out_quotient (q1),
    .out_side     (side_d1)
  );

  // Stage 3: second product and divisor
  side_t       s1;
  logic        v3_r;
  logic        d2_in_ready;
  logic signed [D2_DW-1:0]  dvd2_r;
  logic signed [DIV_VW-1:0] dvs2_r;
  side_t       side3_r;
  logic signed [13:0] mul2_b;
  logic signed [DIV_VW-1:0] dvs2_nxt;
  logic signed [PROD2_W-1:0] prod2;

  assign s1 = side_t'(side_d1);

  always_comb begin
    if (!s1.mode) begin
      mul2_b   = s1.neg ? $signed({7'd0, low_k}) : 14'sd1;
      dvs2_nxt = s1.neg ? DIV_VW'(HUNDRED) : DIV_VW'(1);
    end else begin
      mul2_b   = trimmed ? 14'(s1.trim_diff) : 14'(CODES_PER_DEG);
      dvs2_nxt = trimmed ? DIV_VW'(fuse_q_r) : DIV_VW'(1);
    end
  end

  assign prod2 = PROD2_W'(q1) * PROD2_W'(mul2_b);
  assign adv3  = !v3_r || d2_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv3) begin
      v3_r <= d1_out_valid;
    end
    if (adv3 && d1_out_valid) begin
      dvd2_r  <= prod2[D2_DW-1:0];
      dvs2_r  <= dvs2_nxt;
      side3_r <= s1;
    end
  end

  logic        d2_out_valid, adv_o;
  logic signed [D2_DW-1:0] q2;
  logic [SIDE_W-1:0] side_d2;

  tctc_div #(.DW(D2_DW), .VW(DIV_VW), .SW(SIDE_W)) u_div2 (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (v3_r),
    .in_ready     (d2_in_ready),
    .in_dividend  (dvd2_r),
    .in_divisor   (dvs2_r),
    .in_side      (side3_r),
    .out_valid    (d2_out_valid),
    .out_ready    (adv_o),
    .out_quotient (q2),
    .out_side     (side_d2)
  );

  // Output stage: offset, saturate, hold until taken
  side_t       s2;
  logic signed [SUM_W-1:0] q2_ext, sum;
  logic [31:0] res_nxt;
  logic        out_v_r, err_r;
  logic [31:0] res_r;

  assign s2     = side_t'(side_d2);
  assign q2_ext = SUM_W'(q2);

  always_comb begin
    if (!s2.mode) begin
      sum = (q2_ext < OFFSET_LIMIT) ? q2_ext + SUM_W'(TEMP_OFFSET) : q2_ext;
    end else begin
      sum = q2_ext + $signed({33'd0, s2.trim_low});
    end
    if (s2.err) begin
      res_nxt = '0;
    end else if (sum > I32_MAX) begin
      res_nxt = I32_MAX[31:0];
    end else if (sum < I32_MIN) begin
      res_nxt = I32_MIN[31:0];
    end else begin
      res_nxt = sum[31:0];
    end
  end

  assign adv_o = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv_o) begin
      out_v_r <= d2_out_valid;
    end
    if (adv_o && d2_out_valid) begin
      res_r <= res_nxt;
      err_r <= s2.err;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = res_r;
  assign out_tuser  = err_r;

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import tctc_pkg::*;

  // Direction of one conversion, carried in in_tuser
  localparam bit DIR_CODE_TO_TEMP = 1'b0;
  localparam bit DIR_TEMP_TO_CODE = 1'b1;

  // Calibration mode codes: the two fixed-gain codes and the two trimmed ones
  localparam int unsigned CAL_FIXED_A = 0;
  localparam int unsigned CAL_FIXED_B = 1;
  localparam int unsigned CAL_TRIM_A  = 2;
  localparam int unsigned CAL_TRIM_B  = 3;

  // Arithmetic constants held signed and 64 bits wide, so that negative
  // temperatures keep their sign through every product and quotient
  localparam longint SLOPE_K    = SLOPE_BASE;
  localparam longint OFFSET_K   = TEMP_OFFSET;
  localparam longint KNEE_K     = KNEE_DEG;
  localparam longint GAIN_K     = FIXED_GAIN_NUM;
  localparam longint CENT_K     = HUNDRED;
  localparam longint LOWDIV_K   = LOW_DIV;
  localparam longint CODES_K    = CODES_PER_DEG;
  localparam longint LOW_NUM_K  = 6500;
  localparam longint S32_MAX    = 64'sd2147483647;
  localparam longint S32_MIN    = -64'sd2147483648;

  localparam int VALUE_MAX    = 200000;
  localparam int DRAIN_CYCLES = 100;   // a little above the pipeline latency
  localparam int HOLD_CYCLES  = 400;   // long enough to fill the pipeline
  localparam int STALL_LIMIT  = 3000;  // cycles with no transaction anywhere

  typedef struct {
    logic signed [31:0] result;
    logic               divide_error;
  } conversion_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [14:0] cfg_data = '0;

  // Shadow copy of the calibration registers
  int unsigned slope_adj;
  int unsigned cal_mode;
  int unsigned temp_hi;
  int unsigned temp_lo;

  conversion_t expected_conv_q[$];

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_start = 1'b0;
  int          hold_left = 0;
  int          mismatch_count = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          settings_run = 0;
  int          quiet_cycles = 0;

  thermal_code_temp_converter_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clamp a wide value into the signed 32-bit range
  function automatic longint clamp_s32(longint x);
    if (x > S32_MAX) return S32_MAX;
    if (x < S32_MIN) return S32_MIN;
    return x;
  endfunction

  // Compute the expected conversion from the shadow registers
  function automatic conversion_t convert_expected(bit dir, bit [11:0] tlow, bit [11:0] thigh,
                                                   bit [18:0] raw);
    conversion_t c;
    longint      v;
    longint      t;
    longint      q;
    longint      fuse;
    longint      tdiff;
    longint      f;
    longint      slope;
    bit          trimmed;
    v       = longint'($signed(raw));
    trimmed = cal_mode >= CAL_TRIM_A;
    slope   = SLOPE_K + longint'(slope_adj);
    fuse    = longint'(temp_hi) - longint'(temp_lo);
    tdiff   = longint'(thigh) - longint'(tlow);
    c.result = '0;
    c.divide_error = 1'b0;
    if (dir == DIR_CODE_TO_TEMP) begin
      t = v - longint'(tlow);
      if (trimmed && tdiff == 0) begin
        c.divide_error = 1'b1;
      end else begin
        if (trimmed) q = (t * fuse) / tdiff;
        else q = (t * GAIN_K) / CENT_K;
        if (t < 0) q = (q * (LOW_NUM_K / slope)) / CENT_K;
        // drop the offset where it would push the result past the top
        if (q < S32_MAX - OFFSET_K) q = q + OFFSET_K;
        c.result = 32'(clamp_s32(q));
      end
    end else begin
      t = v - KNEE_K;
      f = fuse / CENT_K;
      if (trimmed && f == 0) begin
        c.divide_error = 1'b1;
      end else begin
        if (t < 0) t = (t * slope) / LOWDIV_K;
        if (trimmed) q = (t * tdiff) / f;
        else q = t * CODES_K;
        c.result = 32'(clamp_s32(q + longint'(tlow)));
      end
    end
    return c;
  endfunction

  // Receiver: random stalls, or a long hold-off once asked for
  always @(posedge clk) begin
    if (hold_start && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each result transaction against the oldest expectation; sample
  // at the falling edge, where everything the next rising edge takes has settled
  always @(negedge clk) begin
    conversion_t exp_c;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_conv_q.size() == 0) begin
        $error("result with nothing expected: result %0d divide_error %0d",
               $signed(out_tdata), out_tuser);
        mismatch_count++;
      end else begin
        exp_c = expected_conv_q.pop_front();
        if (out_tdata !== exp_c.result) begin
          $error("result: expected %0d, actual %0d", exp_c.result, $signed(out_tdata));
          mismatch_count++;
        end
        if (out_tuser !== exp_c.divide_error) begin
          $error("divide_error: expected %0d, actual %0d", exp_c.divide_error, out_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(negedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one conversion and hold it until taken; then idle at random
  task automatic send_conversion(bit dir, bit [11:0] tlow, bit [11:0] thigh, int val);
    bit        taken;
    bit [18:0] raw;
    raw = val[18:0];
    in_tvalid <= 1'b1;
    in_tuser  <= dir;
    in_tdata  <= {5'b0, raw, thigh, tlow};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end
    expected_conv_q.push_back(convert_expected(dir, tlow, thigh, raw));
    items_sent++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drop valid, wait for every result, then let the pipeline settle
  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    while (expected_conv_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register; the block must be idle; valid is left high
  task automatic write_reg(cfg_idx_t idx, int unsigned data);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[14:0];
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end
    case (idx)
      CFG_LOW_SLOPE_ADJUST: slope_adj = data & 32'hF;
      CFG_CALIBRATION_MODE: cal_mode  = data & 32'h3;
      CFG_TEST_TEMP_HIGH:   temp_hi   = data & 32'h7FFF;
      CFG_TEST_TEMP_LOW:    temp_lo   = data & 32'h7FFF;
      default: ;
    endcase
  endtask

  task automatic apply_setting(int unsigned adj, int unsigned cal, int unsigned hi,
                               int unsigned lo);
    drain_pipeline();
    write_reg(CFG_LOW_SLOPE_ADJUST, adj);
    write_reg(CFG_CALIBRATION_MODE, cal);
    write_reg(CFG_TEST_TEMP_HIGH, hi);
    write_reg(CFG_TEST_TEMP_LOW, lo);
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  // Random conversion: mostly full-range values, some near the knee or trim
  task automatic send_random_conversion();
    bit [11:0] tlow;
    bit [11:0] thigh;
    int        val;
    int        pick;
    tlow  = 12'($urandom_range(4095));
    thigh = ($urandom_range(7) == 0) ? tlow : 12'($urandom_range(4095));
    pick  = $urandom_range(9);
    if (pick < 6) val = int'($urandom_range(2 * VALUE_MAX)) - VALUE_MAX;
    else if (pick < 8) val = int'(tlow) + int'($urandom_range(100)) - 50;
    else val = int'($urandom_range(200)) - 100;
    send_conversion(bit'($urandom_range(1)), tlow, thigh, val);
  endtask

  task automatic test_reset_defaults();
    // reset loads adj 6, trimmed mode, 105.00 C / 25.00 C
    send_conversion(DIR_CODE_TO_TEMP, 12'd1000, 12'd2000, 1500);
    send_conversion(DIR_CODE_TO_TEMP, 12'd1000, 12'd2000, 500);
    send_conversion(DIR_TEMP_TO_CODE, 12'd1000, 12'd2000, 85);
    send_conversion(DIR_TEMP_TO_CODE, 12'd1000, 12'd2000, -40);
  endtask

  task automatic test_directed_cases();
    // equal trims: divisor zero in code-to-temperature
    send_conversion(DIR_CODE_TO_TEMP, 12'd2048, 12'd2048, 3000);
    // field extremes and reversed trims
    send_conversion(DIR_CODE_TO_TEMP, 12'd0, 12'd4095, VALUE_MAX);
    send_conversion(DIR_CODE_TO_TEMP, 12'd4095, 12'd0, -VALUE_MAX);
    send_conversion(DIR_TEMP_TO_CODE, 12'd4095, 12'd0, VALUE_MAX);
    send_conversion(DIR_TEMP_TO_CODE, 12'd0, 12'd4095, -VALUE_MAX);
    send_conversion(DIR_TEMP_TO_CODE, 12'd0, 12'd4095, 25);
    send_conversion(DIR_TEMP_TO_CODE, 12'd0, 12'd4095, 24);
    // fuse gap of 107.38 C: one item lands just under the top, one saturates
    apply_setting(15, CAL_TRIM_B, 13238, 2500);
    send_conversion(DIR_CODE_TO_TEMP, 12'd0, 12'd1, 199989);
    send_conversion(DIR_CODE_TO_TEMP, 12'd0, 12'd1, VALUE_MAX);
    send_conversion(DIR_CODE_TO_TEMP, 12'd0, 12'd1, -VALUE_MAX);
    // reversed fuse temperatures
    apply_setting(0, CAL_TRIM_A, 0, 25650);
    send_conversion(DIR_CODE_TO_TEMP, 12'd100, 12'd3000, 2000);
    send_conversion(DIR_TEMP_TO_CODE, 12'd100, 12'd3000, -10);
    send_conversion(DIR_CODE_TO_TEMP, 12'd0, 12'd1, VALUE_MAX);
    // fuse gap below one degree: divisor zero in temperature-to-code
    apply_setting(6, CAL_TRIM_A, 2599, 2500);
    send_conversion(DIR_TEMP_TO_CODE, 12'd10, 12'd20, 60);
    send_conversion(DIR_CODE_TO_TEMP, 12'd10, 12'd20, 60);
    // fixed gain ignores trims, even equal ones
    apply_setting(15, CAL_FIXED_B, 0, 0);
    send_conversion(DIR_CODE_TO_TEMP, 12'd500, 12'd500, 100);
    send_conversion(DIR_CODE_TO_TEMP, 12'd500, 12'd500, 900);
    send_conversion(DIR_TEMP_TO_CODE, 12'd500, 12'd500, -55);
    apply_setting(0, CAL_FIXED_A, 25650, 0);
    send_conversion(DIR_TEMP_TO_CODE, 12'd4095, 12'd0, 150);
    send_conversion(DIR_CODE_TO_TEMP, 12'd4095, 12'd0, 0);
  endtask

  task automatic test_random_sweep();
    int unsigned adj_tab[8] = '{0, 15, 6, 15, 0, 9, 3, 12};
    int unsigned cal_tab[8] = '{CAL_FIXED_A, CAL_FIXED_B, CAL_TRIM_A, CAL_TRIM_B,
                                CAL_TRIM_A, CAL_TRIM_B, CAL_TRIM_A, CAL_FIXED_B};
    int unsigned hi_tab[8]  = '{10500, 0, 25650, 0, 2550, 13238, 25650, 25650};
    int unsigned lo_tab[8]  = '{2500, 0, 0, 25650, 2500, 2500, 25650, 0};
    for (int s = 0; s < 8; s++) begin
      apply_setting(adj_tab[s], cal_tab[s], hi_tab[s], lo_tab[s]);
      // step through the idling phases inside each setting
      for (int p = 0; p < 4; p++) begin
        case (p)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
          default: begin send_idle_pct = 24; recv_stall_pct = 24; end
        endcase
        repeat (28) send_random_conversion();
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // hold the receiver off while the sender keeps offering
    in_tvalid <= 1'b0;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    repeat (120) send_random_conversion();
    // pause until everything is back, then resume
    in_tvalid <= 1'b0;
    while (expected_conv_q.size() != 0) @(posedge clk);
    repeat (30) send_random_conversion();
  endtask

  initial begin
    slope_adj = 6;
    cal_mode  = CAL_TRIM_A;
    temp_hi   = 10500;
    temp_lo   = 2500;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_cases();
    test_random_sweep();
    test_backpressure();
    drain_pipeline();
    $display("covered %0d conversions over %0d calibration settings, %0d results checked",
             items_sent, settings_run, results_seen);
    $display("both directions, divisor-zero, saturation, reversed trims and stalls included");
    if (mismatch_count == 0 && expected_conv_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
